// ===== rtl/core/triangle_zbuffer_rasterizer_macros.svh =====
// ----------------------------------------------------------------------------
// Triangle rasterizer assertion macros
// Shared concurrent assertion forms, clocked on i_clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef TRIANGLE_ZBUFFER_RASTERIZER_MACROS_SVH
`define TRIANGLE_ZBUFFER_RASTERIZER_MACROS_SVH

// Same-cycle implication.
`define TZR_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define TZR_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/tzr_pkg.sv =====
// ----------------------------------------------------------------------------
// tzr_pkg
// Constants, request codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
`default_nettype none

package tzr_pkg;

    localparam int SCREEN_WIDTH  = 128;
    localparam int SCREEN_HEIGHT = 128;
    localparam int PIXEL_COUNT   = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int ADDR_W        = $clog2(PIXEL_COUNT);
    localparam int X_W           = $clog2(SCREEN_WIDTH);
    localparam int Y_W           = $clog2(SCREEN_HEIGHT);

    localparam int COORD_W = 16;
    localparam int Z_W     = 24;
    localparam int GRAY_W  = 8;
    localparam int CNT_W   = 15;
    localparam int COLOR_W = 32;
    localparam int REQ_W   = 2;

    // Bounding box coordinates in whole pixels, signed.
    localparam int BOX_W   = 13;
    // Edge function operands, products and results.
    localparam int DIF_W   = COORD_W + 1;
    localparam int PROD_W  = 2 * DIF_W;
    localparam int EDGE_W  = PROD_W + 1;
    // Weight times depth, split in a low and a high part.
    localparam int LO_W    = 18;
    localparam int MPROD_W = LO_W + Z_W;
    localparam int NUM_W   = EDGE_W + Z_W;
    localparam int Q_W     = Z_W + 1;
    localparam int DIV_STEPS = Q_W;
    localparam int MAC_STEPS = 6;
    localparam int FN_STEPS  = 3;
    localparam int STEP_W    = 5;

    localparam int RAM_W = 1 + GRAY_W + Z_W;

    localparam logic [Z_W-1:0]     DEPTH_MAX  = '1;
    localparam logic [Z_W-1:0]     NEAR_RESET = Z_W'(655);
    localparam logic [CNT_W-1:0]   COUNT_MAX  = '1;
    localparam logic [GRAY_W-1:0]  ALPHA      = '1;

    typedef enum logic [REQ_W-1:0] {
        REQ_CLEAR = 2'd0,
        REQ_DRAW  = 2'd1,
        REQ_READ  = 2'd2
    } t_req;

    // Edge selector: which vertex pair forms the edge.
    localparam logic [1:0] FN_AREA = 2'd2;

    typedef struct packed {
        logic       in_load;
        logic       setup;
        logic       fn_en;
        logic [1:0] fn_sel;
        logic       fn_vtx;
        logic       w_en;
        logic [1:0] w_sel;
        logic       area_en;
        logic       pix_init;
        logic       pix_next;
        logic       rd_pix;
        logic       rd_req;
        logic       rd_capture;
        logic       cull_set;
        logic       mac_en;
        logic [1:0] mac_sel;
        logic       mac_hi;
        logic       acc_clr;
        logic       acc_add;
        logic       div_init;
        logic       div_step;
        logic       pix_write;
        logic       clr_step;
        logic       out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic culled;
        logic area_zero;
        logic box_empty;
        logic in_tri;
        logic last_pix;
        logic clr_last;
    } t_dp_sts;

endpackage

`default_nettype wire

// ===== rtl/core/tzr_ram.sv =====
// ----------------------------------------------------------------------------
// tzr_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tzr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_en,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_en) begin
            r_q <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_q;

endmodule

`default_nettype wire

// ===== rtl/core/tzr_ctrl.sv =====
// ----------------------------------------------------------------------------
// tzr_ctrl
// Request sequencer: clearing pass, triangle setup, per-pixel steps, reads, reply.
// ----------------------------------------------------------------------------
`default_nettype none
`include "triangle_zbuffer_rasterizer_macros.svh"

module tzr_ctrl (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_in_valid,
    output logic                         o_in_stall,
    input  wire logic [tzr_pkg::REQ_W-1:0] i_req_type,
    output logic                         o_out_valid,
    input  wire logic                    i_out_stall,
    output tzr_pkg::t_dp_cmd             o_cmd,
    input  wire tzr_pkg::t_dp_sts        i_sts
);
    import tzr_pkg::*;

    typedef enum logic [14:0] {
        S_CLEAR  = 15'b000000000000001,
        S_IDLE   = 15'b000000000000010,
        S_SETUP  = 15'b000000000000100,
        S_AREA   = 15'b000000000001000,
        S_CHECK  = 15'b000000000010000,
        S_EDGE   = 15'b000000000100000,
        S_TEST   = 15'b000000001000000,
        S_MAC    = 15'b000000010000000,
        S_DIVI   = 15'b000000100000000,
        S_DIV    = 15'b000001000000000,
        S_WRITE  = 15'b000010000000000,
        S_NEXT   = 15'b000100000000000,
        S_RDREQ  = 15'b001000000000000,
        S_RDWAIT = 15'b010000000000000,
        S_DONE   = 15'b100000000000000
    } t_state;

    t_state            r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;
    logic              r_clr_reply, n_clr_reply;
    logic              r_out_valid, n_out_valid;
    t_dp_cmd           cmd;
    logic              out_free;

    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_clr_reply = r_clr_reply;
        cmd         = '0;
        unique case (r_state)
            S_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = r_clr_reply ? S_DONE : S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.in_load = 1'b1;
                    unique case (t_req'(i_req_type))
                        REQ_CLEAR: begin
                            n_state     = S_CLEAR;
                            n_clr_reply = 1'b1;
                        end
                        REQ_DRAW: n_state = S_SETUP;
                        REQ_READ: n_state = S_RDREQ;
                        default:  n_state = S_DONE;
                    endcase
                end
            end
            S_SETUP: begin
                cmd.setup  = 1'b1;
                cmd.fn_en  = 1'b1;
                cmd.fn_sel = FN_AREA;
                cmd.fn_vtx = 1'b1;
                n_state    = S_AREA;
            end
            S_AREA: begin
                cmd.area_en = 1'b1;
                n_state     = S_CHECK;
            end
            S_CHECK: begin
                if (i_sts.culled) begin
                    cmd.cull_set = 1'b1;
                    n_state      = S_DONE;
                end else if (i_sts.area_zero || i_sts.box_empty) begin
                    n_state = S_DONE;
                end else begin
                    cmd.pix_init = 1'b1;
                    n_step       = '0;
                    n_state      = S_EDGE;
                end
            end
            S_EDGE: begin
                // Products of edge k are registered, their difference lands a step later.
                cmd.fn_en  = (r_step < STEP_W'(FN_STEPS));
                cmd.fn_sel = r_step[1:0];
                cmd.w_en   = (r_step != '0);
                cmd.w_sel  = 2'(r_step - 1'b1);
                cmd.rd_pix = (r_step == '0);
                if (r_step == STEP_W'(FN_STEPS)) begin
                    n_step  = '0;
                    n_state = S_TEST;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            S_TEST: begin
                n_state = i_sts.in_tri ? S_MAC : S_NEXT;
            end
            S_MAC: begin
                cmd.mac_en  = (r_step < STEP_W'(MAC_STEPS));
                cmd.mac_sel = r_step[2:1];
                cmd.mac_hi  = r_step[0];
                cmd.acc_clr = (r_step == '0);
                cmd.acc_add = (r_step != '0);
                if (r_step == STEP_W'(MAC_STEPS)) begin
                    n_step  = '0;
                    n_state = S_DIVI;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            S_DIVI: begin
                cmd.div_init = 1'b1;
                n_step       = '0;
                n_state      = S_DIV;
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                if (r_step == STEP_W'(DIV_STEPS - 1)) begin
                    n_step  = '0;
                    n_state = S_WRITE;
                end else begin
                    n_step = r_step + 1'b1;
                end
            end
            S_WRITE: begin
                cmd.pix_write = 1'b1;
                n_state       = S_NEXT;
            end
            S_NEXT: begin
                if (i_sts.last_pix) begin
                    n_state = S_DONE;
                end else begin
                    cmd.pix_next = 1'b1;
                    n_step       = '0;
                    n_state      = S_EDGE;
                end
            end
            S_RDREQ: begin
                cmd.rd_req = 1'b1;
                n_state    = S_RDWAIT;
            end
            S_RDWAIT: begin
                cmd.rd_capture = 1'b1;
                n_state        = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    n_clr_reply  = 1'b0;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (cmd.out_load) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_step      <= '0;
            r_clr_reply <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_clr_reply <= n_clr_reply;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_cmd       = cmd;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    `TZR_ASSERT_NXT(a_accept_leaves_idle, r_state == S_IDLE && i_in_valid,
                    r_state != S_IDLE, "accepted request did not start work")
    `TZR_ASSERT_IMP(a_load_when_free, o_cmd.out_load, !r_out_valid || !i_out_stall,
                    "result register overwritten while still held")
    `TZR_ASSERT_IMP(a_div_bound, r_state == S_DIV, r_step < STEP_W'(DIV_STEPS),
                    "divider ran past its last quotient bit")

endmodule

`default_nettype wire

// ===== rtl/core/tzr_dp.sv =====
// ----------------------------------------------------------------------------
// tzr_dp
// Datapath: request registers, bounding box, edge unit, depth
// multiply-accumulate, serial divider, pixel store and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module tzr_dp (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire tzr_pkg::t_dp_cmd              i_cmd,
    output tzr_pkg::t_dp_sts                   o_sts,
    input  wire logic                          i_cfg_we,
    input  wire logic [tzr_pkg::Z_W-1:0]       i_cfg_data,
    input  wire logic signed [tzr_pkg::COORD_W-1:0] i_ax,
    input  wire logic signed [tzr_pkg::COORD_W-1:0] i_ay,
    input  wire logic [tzr_pkg::Z_W-1:0]       i_az,
    input  wire logic signed [tzr_pkg::COORD_W-1:0] i_bx,
    input  wire logic signed [tzr_pkg::COORD_W-1:0] i_by,
    input  wire logic [tzr_pkg::Z_W-1:0]       i_bz,
    input  wire logic signed [tzr_pkg::COORD_W-1:0] i_cx,
    input  wire logic signed [tzr_pkg::COORD_W-1:0] i_cy,
    input  wire logic [tzr_pkg::Z_W-1:0]       i_cz,
    input  wire logic [tzr_pkg::GRAY_W-1:0]    i_shade,
    output logic [tzr_pkg::COLOR_W-1:0]        o_pixel_color,
    output logic [tzr_pkg::Z_W-1:0]            o_pixel_depth,
    output logic [tzr_pkg::CNT_W-1:0]          o_pixels_written,
    output logic                               o_culled
);
    import tzr_pkg::*;

    localparam logic signed [BOX_W-1:0]   W_BOX = BOX_W'(SCREEN_WIDTH);
    localparam logic signed [BOX_W-1:0]   H_BOX = BOX_W'(SCREEN_HEIGHT);
    localparam logic signed [COORD_W-1:0] W_CRD = COORD_W'(SCREEN_WIDTH);
    localparam logic signed [COORD_W-1:0] H_CRD = COORD_W'(SCREEN_HEIGHT);

    // Request registers.
    logic signed [COORD_W-1:0] r_ax, r_ay, r_bx, r_by, r_cx, r_cy;
    logic [Z_W-1:0]            r_az, r_bz, r_cz;
    logic [GRAY_W-1:0]         r_shade;
    logic [Z_W-1:0]            r_near;

    // Bounding box and pixel walk.
    logic [X_W-1:0] r_xlo, r_xlast, r_x;
    logic [Y_W-1:0] r_ylast, r_y;
    logic           r_box_empty, r_culled;

    // Edge unit.
    logic signed [PROD_W-1:0] r_pa, r_pb;
    logic signed [EDGE_W-1:0] r_w [3];
    logic [EDGE_W-1:0]        r_ar;
    logic                     r_neg;

    // Depth numerator and divider.
    logic [MPROD_W-1:0] r_prod;
    logic               r_prod_hi;
    logic [NUM_W-1:0]   r_acc, r_rem, r_den;
    logic [Q_W-1:0]     r_q;

    // Clearing sweep.
    logic [ADDR_W-1:0] r_clr_addr;

    // Results.
    logic [COLOR_W-1:0] r_res_color, r_out_color;
    logic [Z_W-1:0]     r_res_depth, r_out_depth;
    logic [CNT_W-1:0]   r_res_count, r_out_count;
    logic               r_res_cull, r_out_cull;

    // ---------------------------------------------------------------- box
    logic signed [COORD_W-1:0] xmin, xmax, ymin, ymax;
    logic signed [COORD_W:0]   xmax_e, ymax_e;
    logic signed [BOX_W-1:0]   xfl, yfl, xce, yce, xlo_c, ylo_c, xhi_c, yhi_c;
    logic signed [BOX_W-1:0]   xhm, yhm;

    always_comb begin
        xmin = (r_ax < r_bx) ? r_ax : r_bx;
        xmin = (xmin < r_cx) ? xmin : r_cx;
        ymin = (r_ay < r_by) ? r_ay : r_by;
        ymin = (ymin < r_cy) ? ymin : r_cy;
        xmax = (r_ax > r_bx) ? r_ax : r_bx;
        xmax = (xmax > r_cx) ? xmax : r_cx;
        ymax = (r_ay > r_by) ? r_ay : r_by;
        ymax = (ymax > r_cy) ? ymax : r_cy;
        xmax_e = {xmax[COORD_W-1], xmax} + (COORD_W+1)'(15);
        ymax_e = {ymax[COORD_W-1], ymax} + (COORD_W+1)'(15);
        xfl = {xmin[COORD_W-1], xmin[COORD_W-1:4]};
        yfl = {ymin[COORD_W-1], ymin[COORD_W-1:4]};
        xce = xmax_e[COORD_W:4];
        yce = ymax_e[COORD_W:4];
        xlo_c = (xfl < 0) ? '0 : xfl;
        ylo_c = (yfl < 0) ? '0 : yfl;
        xhi_c = (xce > W_BOX) ? W_BOX : xce;
        yhi_c = (yce > H_BOX) ? H_BOX : yce;
        xhm = xhi_c - BOX_W'(1);
        yhm = yhi_c - BOX_W'(1);
    end

    // ---------------------------------------------------------------- edge unit
    logic signed [DIF_W-1:0]  f_ax, f_ay, f_bx, f_by, f_px, f_py;
    logic signed [DIF_W-1:0]  d_bax, d_bay, d_pax, d_pay;
    logic signed [EDGE_W-1:0] f_diff;

    always_comb begin
        unique case (i_cmd.fn_sel)
            2'd0: begin
                f_ax = {r_bx[COORD_W-1], r_bx}; f_ay = {r_by[COORD_W-1], r_by};
                f_bx = {r_cx[COORD_W-1], r_cx}; f_by = {r_cy[COORD_W-1], r_cy};
            end
            2'd1: begin
                f_ax = {r_cx[COORD_W-1], r_cx}; f_ay = {r_cy[COORD_W-1], r_cy};
                f_bx = {r_ax[COORD_W-1], r_ax}; f_by = {r_ay[COORD_W-1], r_ay};
            end
            default: begin
                f_ax = {r_ax[COORD_W-1], r_ax}; f_ay = {r_ay[COORD_W-1], r_ay};
                f_bx = {r_bx[COORD_W-1], r_bx}; f_by = {r_by[COORD_W-1], r_by};
            end
        endcase
        if (i_cmd.fn_vtx) begin
            f_px = {r_cx[COORD_W-1], r_cx};
            f_py = {r_cy[COORD_W-1], r_cy};
        end else begin
            // Pixel centre at 16x+8 in 12.4 units.
            f_px = $signed(DIF_W'({r_x, 4'b1000}));
            f_py = $signed(DIF_W'({r_y, 4'b1000}));
        end
        d_bax = f_bx - f_ax;
        d_bay = f_by - f_ay;
        d_pax = f_px - f_ax;
        d_pay = f_py - f_ay;
        f_diff = EDGE_W'(r_pa) - EDGE_W'(r_pb);
    end

    logic w_nonneg, w_nonpos;
    always_comb begin
        w_nonneg = !r_w[0][EDGE_W-1] && !r_w[1][EDGE_W-1] && !r_w[2][EDGE_W-1];
        w_nonpos = (r_w[0][EDGE_W-1] || r_w[0] == '0) &&
                   (r_w[1][EDGE_W-1] || r_w[1] == '0) &&
                   (r_w[2][EDGE_W-1] || r_w[2] == '0);
    end

    // ---------------------------------------------------------------- MAC
    logic signed [EDGE_W-1:0] m_w, m_mag;
    logic [LO_W-1:0]          m_part;
    logic [Z_W-1:0]           m_z;

    always_comb begin
        m_w   = r_w[i_cmd.mac_sel];
        // With the area made positive every inside weight is nonnegative.
        m_mag = r_neg ? -m_w : m_w;
        m_part = i_cmd.mac_hi ? LO_W'(m_mag[EDGE_W-1:LO_W]) : m_mag[LO_W-1:0];
        unique case (i_cmd.mac_sel)
            2'd0:    m_z = r_az;
            2'd1:    m_z = r_bz;
            default: m_z = r_cz;
        endcase
    end

    // ---------------------------------------------------------------- divider
    logic [Z_W-1:0] new_depth;
    logic           rem_ge;
    assign rem_ge    = (r_rem >= r_den);
    assign new_depth = r_q[Q_W-1] ? DEPTH_MAX : r_q[Z_W-1:0];

    // ---------------------------------------------------------------- pixel store
    logic [ADDR_W-1:0] pix_addr, rd_addr, ram_addr;
    logic [RAM_W-1:0]  ram_q, ram_wdata;
    logic              ram_we, ram_en, pass;
    logic              in_screen;

    assign pix_addr = ADDR_W'(r_y) * ADDR_W'(SCREEN_WIDTH) + ADDR_W'(r_x);
    assign rd_addr  = ADDR_W'(r_ay[Y_W-1:0]) * ADDR_W'(SCREEN_WIDTH) +
                      ADDR_W'(r_ax[X_W-1:0]);
    assign in_screen = (r_ax >= 0) && (r_ax < W_CRD) && (r_ay >= 0) && (r_ay < H_CRD);
    assign pass     = (new_depth < ram_q[Z_W-1:0]);
    assign ram_we   = i_cmd.clr_step || (i_cmd.pix_write && pass);
    assign ram_en   = i_cmd.rd_pix || i_cmd.rd_req;

    always_comb begin
        if (i_cmd.clr_step) begin
            ram_addr  = r_clr_addr;
            ram_wdata = {1'b0, {GRAY_W{1'b0}}, DEPTH_MAX};
        end else begin
            ram_addr  = i_cmd.rd_req ? rd_addr : pix_addr;
            ram_wdata = {1'b1, r_shade, new_depth};
        end
    end

    tzr_ram #(
        .WIDTH (RAM_W),
        .DEPTH (PIXEL_COUNT)
    ) u_store (
        .i_clk   (i_clk),
        .i_en    (ram_en),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_q)
    );

    // ---------------------------------------------------------------- registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_near     <= NEAR_RESET;
            r_clr_addr <= '0;
        end else begin
            if (i_cfg_we) begin
                r_near <= i_cfg_data;
            end
            if (i_cmd.clr_step) begin
                r_clr_addr <= (r_clr_addr == ADDR_W'(PIXEL_COUNT - 1)) ? '0 :
                              r_clr_addr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.in_load) begin
            r_ax <= i_ax; r_ay <= i_ay; r_az <= i_az;
            r_bx <= i_bx; r_by <= i_by; r_bz <= i_bz;
            r_cx <= i_cx; r_cy <= i_cy; r_cz <= i_cz;
            r_shade <= i_shade;
        end
        if (i_cmd.setup) begin
            r_culled    <= (r_az <= r_near) || (r_bz <= r_near) || (r_cz <= r_near);
            r_box_empty <= !((xlo_c < xhi_c) && (ylo_c < yhi_c));
            r_xlo       <= xlo_c[X_W-1:0];
            r_xlast     <= xhm[X_W-1:0];
            r_ylast     <= yhm[Y_W-1:0];
            r_y         <= ylo_c[Y_W-1:0];
        end
        if (i_cmd.pix_init) begin
            r_x <= r_xlo;
        end
        if (i_cmd.pix_next) begin
            if (r_x == r_xlast) begin
                r_x <= r_xlo;
                r_y <= r_y + 1'b1;
            end else begin
                r_x <= r_x + 1'b1;
            end
        end
        if (i_cmd.fn_en) begin
            r_pa <= d_bax * d_pay;
            r_pb <= d_bay * d_pax;
        end
        if (i_cmd.w_en) begin
            r_w[i_cmd.w_sel] <= f_diff;
        end
        if (i_cmd.area_en) begin
            r_neg <= f_diff[EDGE_W-1];
            r_ar  <= f_diff[EDGE_W-1] ? EDGE_W'(-f_diff) : EDGE_W'(f_diff);
        end
        if (i_cmd.mac_en) begin
            r_prod    <= MPROD_W'(m_part) * MPROD_W'(m_z);
            r_prod_hi <= i_cmd.mac_hi;
        end
        if (i_cmd.acc_clr) begin
            r_acc <= '0;
        end else if (i_cmd.acc_add) begin
            r_acc <= r_acc + (r_prod_hi ? NUM_W'({r_prod, {LO_W{1'b0}}}) :
                                          NUM_W'(r_prod));
        end
        if (i_cmd.div_init) begin
            // Rounding to nearest: add half the area before dividing.
            r_rem <= r_acc + NUM_W'(r_ar >> 1);
            r_den <= {r_ar, {(Q_W-1){1'b0}}};
            r_q   <= '0;
        end else if (i_cmd.div_step) begin
            if (rem_ge) begin
                r_rem <= r_rem - r_den;
            end
            r_q   <= {r_q[Q_W-2:0], rem_ge};
            r_den <= r_den >> 1;
        end
        if (i_cmd.in_load) begin
            r_res_color <= '0;
            r_res_depth <= '0;
            r_res_count <= '0;
            r_res_cull  <= 1'b0;
        end else begin
            if (i_cmd.cull_set) begin
                r_res_cull <= 1'b1;
            end
            if (i_cmd.pix_write && pass && (r_res_count != COUNT_MAX)) begin
                r_res_count <= r_res_count + 1'b1;
            end
            if (i_cmd.rd_capture && in_screen) begin
                r_res_color <= ram_q[RAM_W-1] ?
                    {ALPHA, ram_q[Z_W+:GRAY_W], ram_q[Z_W+:GRAY_W], ram_q[Z_W+:GRAY_W]} :
                    '0;
                r_res_depth <= ram_q[Z_W-1:0];
            end
        end
        if (i_cmd.out_load) begin
            r_out_color <= r_res_color;
            r_out_depth <= r_res_depth;
            r_out_count <= r_res_count;
            r_out_cull  <= r_res_cull;
        end
    end

    always_comb begin
        o_sts.culled    = r_culled;
        o_sts.area_zero = (r_ar == '0);
        o_sts.box_empty = r_box_empty;
        o_sts.in_tri    = w_nonneg || w_nonpos;
        o_sts.last_pix  = (r_x == r_xlast) && (r_y == r_ylast);
        o_sts.clr_last  = (r_clr_addr == ADDR_W'(PIXEL_COUNT - 1));
    end

    assign o_pixel_color    = r_out_color;
    assign o_pixel_depth    = r_out_depth;
    assign o_pixels_written = r_out_count;
    assign o_culled         = r_out_cull;

endmodule

`default_nettype wire

// ===== rtl/core/triangle_zbuffer_rasterizer.sv =====
// ----------------------------------------------------------------------------
// triangle_zbuffer_rasterizer
// Edge-function triangle rasterizer over a gray frame store with a depth store.
// ----------------------------------------------------------------------------
// One request is worked on at a time, one result beat per request. After
// reset the block sweeps the 16384-entry pixel store once and accepts no
// request until that pass ends; a clear request runs the same sweep and then
// replies. A read issues the store read, captures the word and replies. A draw
// sets up the triangle and, unless it is culled, has zero area or an empty box,
// walks its clamped bounding box before it replies: a pixel outside the triangle
// ends after the edge test, one inside runs the depth multiply-accumulate and the
// 25-step serial divider that turns the weighted depth sum into the interpolated depth.
// The result register lets a new request start while a reply is still held.
`default_nettype none

module triangle_zbuffer_rasterizer (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [tzr_pkg::Z_W-1:0]       i_cfg_data,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic [tzr_pkg::REQ_W-1:0]     i_req_type,
    input  wire logic signed [tzr_pkg::COORD_W-1:0] i_ax,
    input  wire logic signed [tzr_pkg::COORD_W-1:0] i_ay,
    input  wire logic [tzr_pkg::Z_W-1:0]       i_az,
    input  wire logic signed [tzr_pkg::COORD_W-1:0] i_bx,
    input  wire logic signed [tzr_pkg::COORD_W-1:0] i_by,
    input  wire logic [tzr_pkg::Z_W-1:0]       i_bz,
    input  wire logic signed [tzr_pkg::COORD_W-1:0] i_cx,
    input  wire logic signed [tzr_pkg::COORD_W-1:0] i_cy,
    input  wire logic [tzr_pkg::Z_W-1:0]       i_cz,
    input  wire logic [tzr_pkg::GRAY_W-1:0]    i_shade,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic [tzr_pkg::COLOR_W-1:0]        o_pixel_color,
    output logic [tzr_pkg::Z_W-1:0]            o_pixel_depth,
    output logic [tzr_pkg::CNT_W-1:0]          o_pixels_written,
    output logic                               o_culled
);
    import tzr_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    tzr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_req_type  (i_req_type),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    tzr_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_data       (i_cfg_data),
        .i_ax             (i_ax),
        .i_ay             (i_ay),
        .i_az             (i_az),
        .i_bx             (i_bx),
        .i_by             (i_by),
        .i_bz             (i_bz),
        .i_cx             (i_cx),
        .i_cy             (i_cy),
        .i_cz             (i_cz),
        .i_shade          (i_shade),
        .o_pixel_color    (o_pixel_color),
        .o_pixel_depth    (o_pixel_depth),
        .o_pixels_written (o_pixels_written),
        .o_culled         (o_culled)
    );

endmodule

`default_nettype wire

// ===== verif/triangle_zbuffer_rasterizer_test.sv =====
// ----------------------------------------------------------------------------
// Triangle rasterizer testbench
// Sends clear, draw and read requests through the valid/stall channels and
// checks every reply against a pixel-accurate copy of the frame and depth
// stores kept in the testbench, across several near-limit settings.
// ----------------------------------------------------------------------------
`default_nettype none

module triangle_zbuffer_rasterizer_test;
    timeunit 1ns;
    timeprecision 1ps;

    import tzr_pkg::*;

    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
    localparam int QUIET_LIMIT = 150000;

    typedef struct packed {
        logic [REQ_W-1:0]          kind;
        logic signed [COORD_W-1:0] ax, ay;
        logic [Z_W-1:0]            az;
        logic signed [COORD_W-1:0] bx, by;
        logic [Z_W-1:0]            bz;
        logic signed [COORD_W-1:0] cx, cy;
        logic [Z_W-1:0]            cz;
        logic [GRAY_W-1:0]         shade;
    } t_beat;

    typedef struct packed {
        logic [COLOR_W-1:0] color;
        logic [Z_W-1:0]     depth;
        logic [CNT_W-1:0]   written;
        logic               culled;
    } t_reply;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [Z_W-1:0] i_cfg_data = '0;
    logic i_in_valid = 1'b0;
    logic o_in_stall;
    t_beat beat_q = '0;
    logic o_out_valid;
    logic i_out_stall = 1'b0;
    logic [COLOR_W-1:0] o_pixel_color;
    logic [Z_W-1:0] o_pixel_depth;
    logic [CNT_W-1:0] o_pixels_written;
    logic o_culled;

    // Testbench copy of the block state.
    logic [GRAY_W:0] gray_mem [PIXEL_COUNT];
    logic [Z_W-1:0] depth_mem [PIXEL_COUNT];
    logic [Z_W-1:0] near_limit = NEAR_RESET;

    t_reply pending_replies[$];
    int errors = 0;
    int quiet_cycles = 0;
    bit idle_mode = 1'b1;
    int hold_left = 0;
    int stall_left = 0;
    int hot_x = 20, hot_y = 20;

    triangle_zbuffer_rasterizer uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall),
        .i_req_type(beat_q.kind),
        .i_ax(beat_q.ax), .i_ay(beat_q.ay), .i_az(beat_q.az),
        .i_bx(beat_q.bx), .i_by(beat_q.by), .i_bz(beat_q.bz),
        .i_cx(beat_q.cx), .i_cy(beat_q.cy), .i_cz(beat_q.cz),
        .i_shade(beat_q.shade),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_pixel_color(o_pixel_color), .o_pixel_depth(o_pixel_depth),
        .o_pixels_written(o_pixels_written), .o_culled(o_culled)
    );

    always #6 i_clk = ~i_clk;

    function automatic longint edge_fn(longint x0, longint y0, longint x1, longint y1,
                                       longint px, longint py);
        return (x1 - x0) * (py - y0) - (y1 - y0) * (px - x0);
    endfunction

    function automatic void clear_stores();
        for (int i = 0; i < PIXEL_COUNT; i++) begin
            gray_mem[i] = '0;
            depth_mem[i] = DEPTH_MAX;
        end
    endfunction

    function automatic t_reply rasterize(t_beat b);
        t_reply r;
        int x0, y0, x1, y1, x2, y2, xlo, xhi, ylo, yhi, idx;
        longint area, ar, w0, w1, w2;
        longint unsigned num, dep;
        r = '0;
        x0 = b.ax; y0 = b.ay; x1 = b.bx; y1 = b.by; x2 = b.cx; y2 = b.cy;
        if (b.kind == REQ_CLEAR) begin
            clear_stores();
        end else if (b.kind == REQ_READ) begin
            if (x0 >= 0 && x0 < SCREEN_WIDTH && y0 >= 0 && y0 < SCREEN_HEIGHT) begin
                idx = y0 * SCREEN_WIDTH + x0;
                if (gray_mem[idx][GRAY_W])
                    r.color = {ALPHA, {3{gray_mem[idx][GRAY_W-1:0]}}};
                r.depth = depth_mem[idx];
            end
        end else if (b.kind == REQ_DRAW) begin
            if (b.az <= near_limit || b.bz <= near_limit || b.cz <= near_limit) begin
                r.culled = 1'b1;
                return r;
            end
            area = edge_fn(x0, y0, x1, y1, x2, y2);
            if (area == 0) return r;
            xlo = (x0 < x1 ? (x0 < x2 ? x0 : x2) : (x1 < x2 ? x1 : x2)) >>> 4;
            ylo = (y0 < y1 ? (y0 < y2 ? y0 : y2) : (y1 < y2 ? y1 : y2)) >>> 4;
            xhi = ((x0 > x1 ? (x0 > x2 ? x0 : x2) : (x1 > x2 ? x1 : x2)) + 15) >>> 4;
            yhi = ((y0 > y1 ? (y0 > y2 ? y0 : y2) : (y1 > y2 ? y1 : y2)) + 15) >>> 4;
            if (xlo < 0) xlo = 0;
            if (ylo < 0) ylo = 0;
            if (xhi > SCREEN_WIDTH) xhi = SCREEN_WIDTH;
            if (yhi > SCREEN_HEIGHT) yhi = SCREEN_HEIGHT;
            for (int y = ylo; y < yhi; y++) begin
                for (int x = xlo; x < xhi; x++) begin
                    w0 = edge_fn(x1, y1, x2, y2, x * 16 + 8, y * 16 + 8);
                    w1 = edge_fn(x2, y2, x0, y0, x * 16 + 8, y * 16 + 8);
                    w2 = edge_fn(x0, y0, x1, y1, x * 16 + 8, y * 16 + 8);
                    if (!((w0 >= 0 && w1 >= 0 && w2 >= 0) ||
                          (w0 <= 0 && w1 <= 0 && w2 <= 0)))
                        continue;
                    ar = area;
                    if (ar < 0) begin
                        ar = -ar; w0 = -w0; w1 = -w1; w2 = -w2;
                    end
                    num = w0 * b.az + w1 * b.bz + w2 * b.cz;
                    dep = (num + ar / 2) / ar;
                    if (dep > DEPTH_MAX) dep = DEPTH_MAX;
                    idx = y * SCREEN_WIDTH + x;
                    if (dep < depth_mem[idx]) begin
                        depth_mem[idx] = dep[Z_W-1:0];
                        gray_mem[idx] = {1'b1, b.shade};
                        if (r.written != COUNT_MAX) r.written++;
                    end
                end
            end
        end
        return r;
    endfunction

    function automatic t_beat draw_beat(int ax, int ay, int bx, int by, int cx, int cy,
                                        int az, int bz, int cz, int shade);
        t_beat b;
        b.kind = REQ_DRAW;
        b.ax = COORD_W'(ax); b.ay = COORD_W'(ay); b.az = Z_W'(az);
        b.bx = COORD_W'(bx); b.by = COORD_W'(by); b.bz = Z_W'(bz);
        b.cx = COORD_W'(cx); b.cy = COORD_W'(cy); b.cz = Z_W'(cz);
        b.shade = GRAY_W'(shade);
        return b;
    endfunction

    function automatic t_beat read_beat(int x, int y);
        t_beat b;
        b = '0;
        b.kind = REQ_READ;
        b.ax = COORD_W'(x); b.ay = COORD_W'(y);
        return b;
    endfunction

    task automatic send_request(t_beat b);
        if (idle_mode && $urandom_range(0, 5) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge i_clk);
        end
        beat_q <= b;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        pending_replies.push_back(rasterize(b));
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pending_replies.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_near(logic [Z_W-1:0] value);
        wait_drained();
        i_cfg_we <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        near_limit = value;
    endtask

    task automatic report_mismatch(string field, longint got, longint want);
        $display("mismatch in %s: got %0h, expected %0h at %0t", field, got, want, $realtime);
        errors++;
    endtask

    // Reply checker.
    always @(posedge i_clk) begin
        t_reply want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_replies.size() == 0) begin
                report_mismatch("unexpected reply", 1, 0);
            end else begin
                want = pending_replies.pop_front();
                if (o_pixel_color != want.color)
                    report_mismatch("pixel_color", o_pixel_color, want.color);
                if (o_pixel_depth != want.depth)
                    report_mismatch("pixel_depth", o_pixel_depth, want.depth);
                if (o_pixels_written != want.written)
                    report_mismatch("pixels_written", o_pixels_written, want.written);
                if (o_culled != want.culled)
                    report_mismatch("culled", o_culled, want.culled);
            end
        end
    end

    // Receiver stalls: a long hold when requested, otherwise random bursts in idle mode.
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            i_out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (stall_left > 0) begin
            i_out_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end else if (idle_mode && $urandom_range(0, 12) == 0) begin
            i_out_stall <= 1'b1;
            stall_left <= $urandom_range(0, 16);
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic test_directed();
        send_request(read_beat(0, 0));
        send_request(read_beat(127, 127));
        send_request(read_beat(-32768, 5));
        send_request(read_beat(5, 32767));
        send_request(read_beat(128, -1));
        begin
            t_beat b;
            b = '1;
            b.kind = REQ_UNUSED;
            send_request(b);
        end
        // Vertex depth equal to the near limit is culled.
        send_request(draw_beat(16, 16, 96, 16, 16, 96, 655, 5000, 5000, 8'h40));
        // Collinear vertices give zero area.
        send_request(draw_beat(16, 16, 64, 64, 112, 112, 9000, 9000, 9000, 8'h41));
        // Same triangle in both windings, the last two vertex depths trading places.
        send_request(draw_beat(32, 32, 160, 48, 64, 144, 70000, 90000, 110000, 8'hA5));
        send_request(draw_beat(32, 32, 64, 144, 160, 48, 70000, 90000, 110000, 8'h5A));
        send_request(read_beat(4, 4));
        send_request(draw_beat(32, 32, 64, 144, 160, 48, 1000, 1000, 1000, 8'hFF));
        send_request(read_beat(4, 4));
        send_request(read_beat(3, 3));
        // Clipped at the screen corner and far off screen.
        send_request(draw_beat(-40, -40, 60, -8, -8, 70, 3000, 4000, 5000, 8'h00));
        send_request(draw_beat(-32768, -32768, -32000, -32768, -32768, -30000,
                               800, 900, 1000, 8'h11));
        send_request(draw_beat(32767, 32767, 32767, 2000, 2000, 32767,
                               24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 8'hFF));
        send_request(draw_beat(2000, 2000, 2040, 2047, 1960, 2047,
                               24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 8'h22));
        send_request(read_beat(0, 0));
        send_request(draw_beat(1200, 1200, 1600, 1250, 1300, 1580, 20000, 400000, 9000000, 8'h77));
        send_request(read_beat(90, 85));
        send_request(read_beat(127, 0));
        send_request(draw_beat(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
        send_request(beat_q.kind == REQ_DRAW ? read_beat(80, 80) : read_beat(81, 81));
        begin
            t_beat b;
            b = '0;
            b.kind = REQ_CLEAR;
            send_request(b);
        end
        send_request(read_beat(4, 4));
    endtask

    task automatic test_near_limit();
        write_near('0);
        send_request(draw_beat(320, 320, 400, 330, 340, 400, 0, 1, 1, 8'h10));
        send_request(draw_beat(320, 320, 400, 330, 340, 400, 1, 1, 1, 8'h10));
        send_request(read_beat(21, 21));
        write_near(24'hFFFFFF);
        send_request(draw_beat(320, 320, 400, 330, 340, 400,
                               24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 8'h20));
        write_near(24'($urandom));
        send_request(draw_beat(320, 320, 400, 330, 340, 400,
                               24'hFFFFFE, 24'hFFFFFF, 24'hFFFFFE, 8'h30));
        send_request(read_beat(21, 21));
        write_near(NEAR_RESET);
    endtask

    task automatic test_backpressure();
        wait_drained();
        hold_left = 400;
        for (int i = 0; i < 20; i++)
            send_request(read_beat($urandom_range(0, 127), $urandom_range(0, 127)));
    endtask

    task automatic random_beat(output t_beat b);
        int sel, bx0, by0;
        logic [223:0] noise;
        b = '0;
        sel = $urandom_range(0, 199);
        if (sel < 2) begin
            b.kind = REQ_CLEAR;
        end else if (sel < 4) begin
            noise = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
            b = noise[$bits(t_beat)-1:0];
            b.kind = REQ_UNUSED;
        end else if (sel < 16) begin
            // Noise draw: culled by a near vertex or kept off screen.
            noise = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
            b = noise[$bits(t_beat)-1:0];
            b.kind = REQ_DRAW;
            if ($urandom_range(0, 1)) begin
                b.bz = Z_W'($urandom_range(0, near_limit));
            end else if ($urandom_range(0, 1)) begin
                b.ay[15] = 1'b1; b.by[15] = 1'b1; b.cy[15] = 1'b1;
            end else begin
                b.ay = COORD_W'($urandom_range(2048, 32767));
                b.by = COORD_W'($urandom_range(2048, 32767));
                b.cy = COORD_W'($urandom_range(2048, 32767));
            end
        end else if (sel < 24) begin
            b = read_beat(16'($urandom), 16'($urandom));
        end else if (sel < 80) begin
            b = read_beat(hot_x + $urandom_range(0, 6) - 1, hot_y + $urandom_range(0, 6) - 1);
        end else begin
            if ($urandom_range(0, 2) == 0) begin
                hot_x = $urandom_range(0, 135) - 4;
                hot_y = $urandom_range(0, 135) - 4;
            end
            bx0 = hot_x * 16;
            by0 = hot_y * 16;
            b = draw_beat(bx0 + $urandom_range(0, 80), by0 + $urandom_range(0, 80),
                          bx0 + $urandom_range(0, 80), by0 + $urandom_range(0, 80),
                          bx0 + $urandom_range(0, 80), by0 + $urandom_range(0, 80),
                          $urandom_range(700, 300000), $urandom_range(700, 300000),
                          $urandom_range(700, 300000), $urandom_range(0, 255));
        end
    endtask

    task automatic test_random(int count);
        t_beat b;
        for (int i = 0; i < count; i++) begin
            if (i == count - 150) idle_mode = 1'b0;
            else if (i % 200 == 100) idle_mode = 1'b0;
            else if (i % 200 == 140 && i < count - 150) idle_mode = 1'b1;
            random_beat(b);
            send_request(b);
        end
    endtask

    initial begin
        clear_stores();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_near_limit();
        test_backpressure();
        test_random(900);
        wait_drained();
        repeat (64) @(posedge i_clk);
        if (errors == 0 && pending_replies.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

`default_nettype wire
